FILE: hw/rtl/ptm_pkg.sv
// Shared constants and controller/datapath interface types for the pH trimmed-mean block.
package ptm_pkg;

   localparam int CODE_W        = 12;
   localparam int PH_W          = 14;
   localparam int ADC_FULL      = 4095;
   localparam int PH_FULL_MILLI = 14000;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_READ_FAIL = 1'b1;

   typedef struct packed {
      logic load;
      logic write;
      logic sweep;
      logic trim;
      logic mult;
      logic result;
   } ptm_cmd_type;

   typedef struct packed {
      logic sweep_last;
   } ptm_stat_type;

endpackage

FILE: hw/rtl/ph_trimmed_mean_ring.sv
// Top level of the pH trimmed-mean moving average over a ring of ADC samples.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_sample[11:0], req_read_error
//   rsp_      out        rsp_valid/rsp_stall  rsp_status, rsp_mean_code[11:0],
//                                             rsp_ph_milli[13:0]
//
// A good sample goes through one ring write, SAMPLES ring reads at one per cycle, then
// the tail, trim, multiply and result stages.
// A failed read skips the ring and goes straight to the result stage.
// req_stall is high after the accept until the result is loaded, so no new sample is taken
// while one is in flight; a stalled earlier result delays the load.
// Synchronous reset returns to idle and marks every ring entry as zero.
module ph_trimmed_mean_ring #(
   parameter int SAMPLES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_sample,
   input  logic        req_read_error,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [11:0] rsp_mean_code,
   output logic [13:0] rsp_ph_milli
);
   import ptm_pkg::*;

   ptm_cmd_type  cmd;
   ptm_stat_type stat;

   ptm_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_read_error (req_read_error),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .stat           (stat),
      .cmd            (cmd)
   );

   ptm_dpath #(
      .SAMPLES (SAMPLES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_sample     (req_sample),
      .req_read_error (req_read_error),
      .rsp_status     (rsp_status),
      .rsp_mean_code  (rsp_mean_code),
      .rsp_ph_milli   (rsp_ph_milli)
   );

endmodule

FILE: hw/rtl/ptm_dpath.sv
// Datapath: sample ring memory, min/max/sum sweep, trim and reciprocal-multiply scaling.
module ptm_dpath #(
   parameter int SAMPLES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ptm_pkg::ptm_cmd_type   cmd,
   output ptm_pkg::ptm_stat_type  stat,
   input  logic [11:0]            req_sample,
   input  logic                   req_read_error,
   output logic                   rsp_status,
   output logic [11:0]            rsp_mean_code,
   output logic [13:0]            rsp_ph_milli
);
   import ptm_pkg::*;

   localparam int AW     = $clog2(SAMPLES);
   localparam int KEEP   = SAMPLES - 2;
   localparam int SW     = $clog2(ADC_FULL * SAMPLES + 1);
   localparam int PH_DIV = ADC_FULL * KEEP;
   // Both constant divisions are a multiply by a rounded-up reciprocal and a shift.
   // With the shift at SW plus the divisor's bit count, the reciprocal error never
   // moves the truncated quotient for any trimmed sum below 2**SW.
   localparam int SM = SW + $clog2(KEEP);
   localparam longint unsigned CM = ((64'd1 << SM) + 64'(KEEP) - 64'd1) / 64'(KEEP);
   localparam int MW = SW + $clog2(CM + 1);
   localparam int SP = SW + $clog2(PH_DIV);
   localparam longint unsigned CP =
      (64'(PH_FULL_MILLI) * (64'd1 << SP) + 64'(PH_DIV) - 64'd1) / 64'(PH_DIV);
   localparam int PW = SW + $clog2(CP + 1);

   logic [CODE_W-1:0] ring_mem [SAMPLES];
   logic [SAMPLES-1:0] valid_ff;
   logic [AW-1:0]      wr_pos_ff;

   logic [CODE_W-1:0] sample_ff;
   logic              err_ff;

   logic [AW-1:0]     rd_addr_ff;
   logic [CODE_W-1:0] rd_data_ff;
   logic              rd_vld_ff;
   logic              acc_en_ff;

   logic [SW-1:0]     sum_ff;
   logic [CODE_W-1:0] max_ff;
   logic [CODE_W-1:0] min_ff;
   logic [SW-1:0]     trim_ff;
   logic [MW-1:0]     prod_m_ff;
   logic [PW-1:0]     prod_p_ff;

   logic              status_ff;
   logic [CODE_W-1:0] mean_ff;
   logic [PH_W-1:0]   ph_ff;

   logic [CODE_W-1:0] acc_val;
   logic [CODE_W-1:0] mean_q;
   logic [PH_W-1:0]   ph_q;
   logic [PH_W-1:0]   ph_sat;

   // Entries never written since reset read as zero.
   assign acc_val = rd_vld_ff ? rd_data_ff : '0;

   assign mean_q = CODE_W'(prod_m_ff >> SM);
   assign ph_q   = PH_W'(prod_p_ff >> SP);
   assign ph_sat = (ph_q > PH_W'(PH_FULL_MILLI)) ? PH_W'(PH_FULL_MILLI) : ph_q;

   assign stat.sweep_last = (rd_addr_ff == AW'(SAMPLES - 1));

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         ring_mem[wr_pos_ff] <= sample_ff;
      end
      rd_data_ff <= ring_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         wr_pos_ff <= '0;
         acc_en_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         acc_en_ff <= cmd.sweep;
         rd_vld_ff <= valid_ff[rd_addr_ff];
         if (cmd.write) begin
            valid_ff[wr_pos_ff] <= 1'b1;
            if (wr_pos_ff == AW'(SAMPLES - 1)) begin
               wr_pos_ff <= '0;
            end else begin
               wr_pos_ff <= wr_pos_ff + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff  <= req_sample;
         err_ff     <= req_read_error;
         rd_addr_ff <= '0;
         sum_ff     <= '0;
         max_ff     <= '0;
         min_ff     <= CODE_W'(ADC_FULL);
      end else begin
         if (cmd.sweep) begin
            rd_addr_ff <= rd_addr_ff + AW'(1);
         end
         if (acc_en_ff) begin
            sum_ff <= sum_ff + SW'(acc_val);
            if (acc_val > max_ff) begin
               max_ff <= acc_val;
            end
            if (acc_val < min_ff) begin
               min_ff <= acc_val;
            end
         end
      end
      if (cmd.trim) begin
         trim_ff <= sum_ff - SW'(max_ff) - SW'(min_ff);
      end
      if (cmd.mult) begin
         prod_m_ff <= MW'(trim_ff) * MW'(CM);
         prod_p_ff <= PW'(trim_ff) * PW'(CP);
      end
      if (cmd.result) begin
         if (err_ff) begin
            status_ff <= STATUS_READ_FAIL;
            mean_ff   <= '0;
            ph_ff     <= '0;
         end else begin
            status_ff <= STATUS_OK;
            mean_ff   <= mean_q;
            ph_ff     <= ph_sat;
         end
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_mean_code = mean_ff;
   assign rsp_ph_milli  = ph_ff;

endmodule

FILE: hw/rtl/ptm_ctrl.sv
// Controller state machine that sequences one item through the datapath.
module ptm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_read_error,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  ptm_pkg::ptm_stat_type  stat,
   output ptm_pkg::ptm_cmd_type   cmd
);
   import ptm_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      WRITE,
      SWEEP,
      TAIL,
      TRIM,
      MULT,
      FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

   // A new result is loaded, or a waiting one is held while it is stalled.
   assign rsp_valid_in = cmd.result || (rsp_valid_ff && rsp_stall);

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == IDLE) && req_valid;
      cmd.write    = (state_ff == WRITE);
      cmd.sweep    = (state_ff == SWEEP);
      cmd.trim     = (state_ff == TRIM);
      cmd.mult     = (state_ff == MULT);
      cmd.result   = (state_ff == FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  state_ff <= req_read_error ? FINISH : WRITE;
               end
            end
            WRITE:    state_ff <= SWEEP;
            SWEEP: begin
               if (stat.sweep_last) begin
                  state_ff <= TAIL;
               end
            end
            TAIL:     state_ff <= TRIM;
            TRIM:     state_ff <= MULT;
            MULT:     state_ff <= FINISH;
            FINISH: begin
               if (out_free) begin
                  state_ff <= IDLE;
               end
            end
            default:  state_ff <= IDLE;
         endcase
      end
   end

   a_good_item_writes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE && req_valid && !req_read_error) |=> (state_ff == WRITE))
      else $error("accepted sample did not go to the ring write");

   a_sweep_covers_ring: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SWEEP && !stat.sweep_last) |=> (state_ff == SWEEP))
      else $error("ring sweep ended early");

   a_mult_to_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == MULT) |=> (state_ff == FINISH))
      else $error("scaling did not hand over to the result stage");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == FINISH))
      else $error("result shown without passing the result stage");

endmodule
